FILE: rtl/msort_pkg.sv
package msort_pkg;

    // default store depth and fixed field widths
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 64;
    localparam int SET_CNT_W    = 7;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MED_RD,
        ST_MED_LD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic start;   // item accepted, begin insertion or flag overflow
        logic shift;   // one compare and move step of the insertion
        logic med_rd;  // read the median entry
        logic med_ld;  // load the result register and clear the set
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;     // store holds capacity keys
        logic go_down;  // entry below the gap is larger than the key
        logic last;     // item being inserted closes the set
        logic out_free; // result register can take a new result
    } t_sts;

endpackage

FILE: rtl/msort_ctrl.sv
module msort_ctrl
    import msort_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (!i_sts.full) begin
                        n_state = ST_SHIFT;
                    end else if (i_last) begin
                        n_state = ST_MED_RD;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (!i_sts.go_down) begin
                    n_state = i_sts.last ? ST_MED_RD : ST_IDLE;
                end
            end
            ST_MED_RD: begin
                o_cmd.med_rd = 1'b1;
                n_state      = ST_MED_LD;
            end
            ST_MED_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.med_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/msort_dp.sv
module msort_dp
    import msort_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [KEY_W-1:0]     i_key,
    input  logic                 i_last,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [KEY_W-1:0]     o_median_key,
    output logic [SET_CNT_W-1:0] o_set_count,
    output logic                 o_overflowed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // sorted store
    logic [KEY_W-1:0] r_mem [0:CAPACITY-1];
    logic [KEY_W-1:0] r_rdata;

    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_pos;
    logic             r_last;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic             r_out_valid;
    logic [KEY_W-1:0] r_median_key;
    logic [SET_CNT_W-1:0] r_set_count;
    logic             r_overflowed;

    logic             w_full;
    logic             w_go_down;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [KEY_W-1:0] w_wd;
    logic [AW-1:0]    w_cnt_lo;

    assign w_cnt_lo  = r_count[AW-1:0];
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_go_down = (r_pos != '0) && (r_rdata > r_key);

    // status to controller
    always_comb begin
        o_sts          = '0;
        o_sts.full     = w_full;
        o_sts.go_down  = w_go_down;
        o_sts.last     = r_last;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // memory read and write port selection
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_we      = 1'b0;
        w_wa      = r_pos;
        w_wd      = r_key;
        if (i_cmd.start && !w_full && (r_count != '0)) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_cnt_lo - AW'(1);
        end
        if (i_cmd.shift) begin
            w_we = 1'b1;
            if (w_go_down) begin
                w_wd = r_rdata;
                if (r_pos != AW'(1)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_pos - AW'(2);
                end
            end
        end
        if (i_cmd.med_rd) begin
            w_rd_en   = 1'b1;
            w_rd_addr = AW'(r_count >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // insertion key, gap position and set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_last <= i_last;
                end
            end
            if (i_cmd.shift && !w_go_down) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.med_ld) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_key;
            r_pos <= w_cnt_lo;
        end else if (i_cmd.shift && w_go_down) begin
            r_pos <= r_pos - AW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.med_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_ld) begin
            r_median_key <= r_rdata;
            r_set_count  <= SET_CNT_W'(r_count);
            r_overflowed <= r_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_median_key = r_median_key;
    assign o_set_count  = r_set_count;
    assign o_overflowed = r_overflowed;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.med_ld |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a waiting result");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.med_ld |=> (r_count == '0) && !r_ovf && r_out_valid)
        else $error("set not cleared after result");

    a_shift_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && w_go_down) |-> (r_pos != '0) && (r_count != '0))
        else $error("shift below the bottom of the store");
`endif

endmodule

FILE: rtl/median_by_insertion_sort.sv
// channel  dir  handshake                 payload
// input    in   i_in_valid / o_in_stall   i_key, i_last
// output   out  o_out_valid / i_out_stall o_median_key, o_set_count, o_overflowed
//
// an item is accepted, then each stored key larger than it is moved up one entry
// (one read and one write of the store per step), then the key is written into the gap;
// a dropped key (store full) is only accepted and flags overflow
// an item marked last then has the median entry read and loaded into the result
// register, which waits while that register still holds a result not yet taken
// reset (synchronous, active low) empties the set; the store itself is not cleared
// i_out_stall holds the result; the next item is taken meanwhile
module median_by_insertion_sort
    import msort_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KEY_W-1:0]     i_key,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEY_W-1:0]     o_median_key,
    output logic [SET_CNT_W-1:0] o_set_count,
    output logic                 o_overflowed
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    msort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // store, insertion datapath and result register
    msort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_key        (i_key),
        .i_last       (i_last),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_median_key (o_median_key),
        .o_set_count  (o_set_count),
        .o_overflowed (o_overflowed)
    );

endmodule

FILE: dv/median_by_insertion_sort_tb.sv
`timescale 1ns / 100ps

module median_by_insertion_sort_tb;
    import msort_pkg::*;

    // one median result as the block reports it
    typedef struct packed {
        logic [KEY_W-1:0]     median_key;
        logic [SET_CNT_W-1:0] set_count;
        logic                 overflowed;
    } t_median_result;

    // keeps its own sorted copy of the open set and the medians still owed
    class median_predictor;
        logic [KEY_W-1:0] sorted_keys [CAPACITY_DEF];
        int               key_count;
        bit               keys_dropped;
        t_median_result   pending_medians [$];
        int               errors;

        function new();
            key_count    = 0;
            keys_dropped = 0;
            errors       = 0;
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // insert an accepted key; an item marked last closes the set
        function void note_key(logic [KEY_W-1:0] key, logic last);
            int             pos;
            t_median_result res;
            if (key_count >= CAPACITY_DEF) begin
                keys_dropped = 1;
            end else begin
                pos = key_count;
                while (pos > 0 && sorted_keys[pos-1] > key) begin
                    sorted_keys[pos] = sorted_keys[pos-1];
                    pos--;
                end
                sorted_keys[pos] = key;
                key_count++;
            end
            if (last) begin
                res.median_key = sorted_keys[key_count/2];
                res.set_count  = key_count[SET_CNT_W-1:0];
                res.overflowed = keys_dropped;
                pending_medians.push_back(res);
                key_count    = 0;
                keys_dropped = 0;
            end
        endfunction

        // compare a result with the oldest median owed
        function void check_median(logic [KEY_W-1:0] med, logic [SET_CNT_W-1:0] cnt,
                                   logic ovf);
            t_median_result want;
            if (pending_medians.size() == 0) begin
                report_error($sformatf("unexpected result: median %h count %0d ovf %b",
                                       med, cnt, ovf));
                return;
            end
            want = pending_medians.pop_front();
            if (med !== want.median_key || cnt !== want.set_count
                    || ovf !== want.overflowed) begin
                report_error($sformatf(
                    "mismatch: exp median %h count %0d ovf %b, got median %h count %0d ovf %b",
                    want.median_key, want.set_count, want.overflowed, med, cnt, ovf));
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [KEY_W-1:0]     i_key       = '0;
    logic                 i_last      = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KEY_W-1:0]     o_median_key;
    logic [SET_CNT_W-1:0] o_set_count;
    logic                 o_overflowed;

    median_predictor medians = new();
    int              accepted_keys = 0;

    median_by_insertion_sort dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key        (i_key),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_median_key (o_median_key),
        .o_set_count  (o_set_count),
        .o_overflowed (o_overflowed)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("median_by_insertion_sort_tb failed");
        $finish;
    end

    // offer one key, wait for it to be taken
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last, input bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_key      = key;
        i_last     = last;
        do @(posedge i_clk); while (o_in_stall);
        medians.note_key(key, last);
        accepted_keys++;
        @(negedge i_clk);
    endtask

    // hold off until every median owed has come out
    task automatic drain_medians();
        i_in_valid = 1'b0;
        while (medians.pending_medians.size() != 0) @(negedge i_clk);
    endtask

    // draw one key in the style of the current set
    function automatic logic [KEY_W-1:0] pick_key(int style, int idx,
                                                  logic [KEY_W-1:0] base);
        logic [KEY_W-1:0] k;
        case (style)
            0: k = {$urandom, $urandom};
            1: k = KEY_W'($urandom_range(0, 7));
            2: begin
                case ($urandom_range(0, 4))
                    0: k = '0;
                    1: k = '1;
                    2: k = 64'd1;
                    3: k = {1'b1, 63'd0};
                    default: k = {1'b0, {63{1'b1}}};
                endcase
            end
            3: k = base - KEY_W'(idx);
            default: k = base + KEY_W'(idx);
        endcase
        return k;
    endfunction

    // result side with random stalls and stall-free stretches
    initial begin
        int n;
        int quiet_left;
        quiet_left = 0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (quiet_left == 0 && $urandom_range(0, 4) == 0) begin
                quiet_left = $urandom_range(5, 20);
            end
            if (quiet_left > 0) begin
                n = 0;
                quiet_left--;
            end else begin
                n = $urandom_range(0, 9);
            end
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            medians.check_median(o_median_key, o_set_count, o_overflowed);
            @(negedge i_clk);
        end
    end

    // reset, directed sets, random sets, drain
    initial begin
        int               set_size;
        int               style;
        bit               quiet;
        logic [KEY_W-1:0] base;
        int               r;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single-key sets at both extremes
        send_key('0, 1'b1, 1'b0);
        send_key('1, 1'b1, 1'b0);
        // even count gives the upper median
        send_key(64'd5, 1'b0, 1'b0);
        send_key(64'd3, 1'b1, 1'b0);
        // descending keys shift the whole store each time
        send_key('1, 1'b0, 1'b1);
        send_key({{63{1'b1}}, 1'b0}, 1'b0, 1'b1);
        send_key({1'b1, 63'd0}, 1'b0, 1'b1);
        send_key(64'd1, 1'b0, 1'b1);
        send_key('0, 1'b1, 1'b1);
        // equal keys do not move each other
        send_key(64'd7, 1'b0, 1'b0);
        send_key(64'd7, 1'b0, 1'b0);
        send_key(64'd7, 1'b0, 1'b0);
        send_key(64'd2, 1'b1, 1'b0);
        // ascending keys need no shifting
        send_key(64'd10, 1'b0, 1'b0);
        send_key(64'd20, 1'b0, 1'b0);
        send_key(64'd30, 1'b1, 1'b0);
        // alternating bit patterns
        send_key({32{2'b10}}, 1'b0, 1'b0);
        send_key({32{2'b01}}, 1'b1, 1'b0);
        drain_medians();

        // random sets, mostly small, a few filling or overflowing the store
        while (accepted_keys < 620) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                set_size = $urandom_range(CAPACITY_DEF - 4, CAPACITY_DEF + 6);
            end else if (r < 3) begin
                set_size = 1;
            end else begin
                set_size = $urandom_range(2, 12);
            end
            style = $urandom_range(0, 4);
            base  = {$urandom, $urandom};
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_size; i++) begin
                send_key(pick_key(style, i, base), i == set_size - 1, quiet);
            end
            if ($urandom_range(0, 7) == 0) begin
                drain_medians();
            end
        end

        // wait out the last results, then let the block settle
        drain_medians();
        repeat (CAPACITY_DEF + 8) @(negedge i_clk);
        if (medians.errors == 0 && medians.pending_medians.size() == 0) begin
            $display("median_by_insertion_sort_tb passed");
        end else begin
            $display("median_by_insertion_sort_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/msort_pkg.sv
rtl/msort_ctrl.sv
rtl/msort_dp.sv
rtl/median_by_insertion_sort.sv
dv/median_by_insertion_sort_tb.sv
